[rtl/core/kdb_pkg.sv]
// Shared types and constants for the key debounce block.
// No dependencies; used by kdb_track and the top level.
`timescale 1ns / 1ps

package kdb_pkg;

	localparam int unsigned FILTER_LEN_DEF = 3;

	localparam logic [7:0]  NO_KEY          = 8'hFF;
	localparam logic [7:0]  HELD_RESET      = 8'h00;
	localparam logic [15:0] LONG_TICKS_DEF  = 16'd300;
	localparam logic [15:0] HOLD_MAX        = 16'hFFFF;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;
	localparam logic [1:0] EV_LONG    = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] code;
		logic [7:0] held;
	} event_t;

endpackage

[rtl/core/kdb_track.sv]
// Debounce filter and press/release/long-press tracker; holds all key state.
// Depends on kdb_pkg. Processes one sample per cycle when step is high.
`timescale 1ns / 1ps

module kdb_track #(
	parameter int unsigned FILTER_LEN = kdb_pkg::FILTER_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         sample,
	input  logic [15:0]        long_ticks,
	output kdb_pkg::event_t    result
);

	localparam int unsigned HIST_LEN = FILTER_LEN - 1;

	logic [7:0]  hist_q [HIST_LEN];
	logic [7:0]  cand_q, cand_n;
	logic [7:0]  pressed_q, pressed_n;
	logic [15:0] hold_q, hold_n;
	logic [7:0]  held_q, held_n;
	logic [15:0] hold_inc;
	logic        stable;

	assign hold_inc = hold_q + 16'd1;

	always_comb begin
		stable = 1'b1;
		for (int i = 0; i < HIST_LEN; i++) begin
			if (hist_q[i] != sample) stable = 1'b0;
		end
	end

	always_comb begin
		cand_n      = cand_q;
		pressed_n   = pressed_q;
		hold_n      = hold_q;
		held_n      = held_q;
		result.kind = kdb_pkg::EV_NONE;
		result.code = kdb_pkg::NO_KEY;
		if (!stable) begin
			// noisy sample: only shift it in
		end else if (sample == kdb_pkg::NO_KEY) begin
			if (pressed_q == kdb_pkg::NO_KEY) begin
				cand_n = kdb_pkg::NO_KEY;
				hold_n = '0;
			end else if (cand_q != kdb_pkg::NO_KEY) begin
				cand_n = kdb_pkg::NO_KEY;
			end else begin
				held_n      = kdb_pkg::NO_KEY;
				hold_n      = '0;
				pressed_n   = kdb_pkg::NO_KEY;
				result.kind = kdb_pkg::EV_RELEASE;
				result.code = pressed_q;
			end
		end else if (pressed_q == kdb_pkg::NO_KEY) begin
			if (sample == cand_q) begin
				pressed_n   = sample;
				hold_n      = 16'd1;
				held_n      = sample;
				result.kind = kdb_pkg::EV_PRESS;
				result.code = sample;
			end else begin
				cand_n = sample;
			end
		end else if (sample != cand_q) begin
			cand_n = sample;
		end else if (pressed_q == sample) begin
			// saturate the hold count so the long press fires once per hold
			if (hold_q != kdb_pkg::HOLD_MAX) begin
				hold_n = hold_inc;
				if (hold_inc == long_ticks) begin
					result.kind = kdb_pkg::EV_LONG;
					result.code = sample;
				end
			end
		end else begin
			// a different key replaced the held one: release it first
			held_n      = kdb_pkg::NO_KEY;
			hold_n      = '0;
			cand_n      = kdb_pkg::NO_KEY;
			pressed_n   = kdb_pkg::NO_KEY;
			result.kind = kdb_pkg::EV_RELEASE;
			result.code = pressed_q;
		end
		result.held = held_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++) hist_q[i] <= kdb_pkg::NO_KEY;
			cand_q    <= kdb_pkg::NO_KEY;
			pressed_q <= kdb_pkg::NO_KEY;
			hold_q    <= '0;
			held_q    <= kdb_pkg::HELD_RESET;
		end else if (step) begin
			for (int i = HIST_LEN - 1; i > 0; i--) hist_q[i] <= hist_q[i - 1];
			hist_q[0] <= sample;
			cand_q    <= cand_n;
			pressed_q <= pressed_n;
			hold_q    <= hold_n;
			held_q    <= held_n;
		end
	end

endmodule

[rtl/core/key_debounce_press_release_longpress.sv]
// Key debounce with press, release and long-press events: top level.
// Depends on kdb_pkg and kdb_track.
//
// Usage:
//   Input channel (in_valid / in_stall / scan_code): one raw scan code per
//   transfer, 255 meaning no key. A transfer happens when in_valid is high
//   and in_stall is low.
//   Output channel (out_valid / out_stall / event_kind, event_code,
//   held_code): exactly one result per input transfer, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_data): writes the long-press
//   tick count; cfg_ready is always high. Write it only while idle.
// Timing:
//   out_valid rises after the input transfer once the item has passed the
//   input register, then the filter/tracker logic feeding the result
//   register; an output stall can hold it in the input register.
//   Throughput is one item per cycle while out_stall is low, since
//   kdb_track updates its state on every advance.
// Reset (arst_n low): history, candidate and pressed code go to 255, hold
//   count to 0, held code to 0, long-press ticks to 300; both stages empty.
// Stall: while out_stall holds a result, the input register keeps its item
//   and in_stall rises once that register is full; nothing is dropped.
`timescale 1ns / 1ps

module key_debounce_press_release_longpress #(
	parameter int unsigned FILTER_LEN = kdb_pkg::FILTER_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  scan_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [7:0]  event_code,
	output logic [7:0]  held_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic            vld_s1;
	logic [7:0]      scan_s1;
	logic            out_valid_q;
	kdb_pkg::event_t res_q;
	kdb_pkg::event_t res;
	logic [15:0]     long_ticks_q;
	logic            advance;
	logic            in_take;

	// Advance the staged sample whenever the result register is free
	// or is being emptied this cycle.
	assign advance  = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q <= kdb_pkg::LONG_TICKS_DEF;
		end else if (cfg_valid) begin
			long_ticks_q <= cfg_data;
		end
	end

	// Input register: hold the sample until the tracker takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			scan_s1 <= scan_code;
		end
	end

	kdb_track #(
		.FILTER_LEN (FILTER_LEN)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.sample     (scan_s1),
		.long_ticks (long_ticks_q),
		.result     (res)
	);

	// Result register: load on advance, drop after the output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = res_q.kind;
	assign event_code = res_q.code;
	assign held_code  = res_q.held;

endmodule
